FILE: sv/pps_pkg.sv
// shared types and constants of the projection profile segmenter
// used by pps_walk, projection_profile_segmenter_unit and tb_top; no dependencies
package pps_pkg;

  localparam int unsigned ROW_OUT_W = 12;
  localparam int unsigned COL_OUT_W = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  typedef logic [ROW_OUT_W-1:0] row_out_t;
  typedef logic [COL_OUT_W-1:0] col_out_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes of the configuration port
  localparam cfg_idx_t REG_DARK_THRESHOLD = 1'd0;
  localparam cfg_idx_t REG_IMAGE_WIDTH = 1'd1;

  localparam cfg_data_t THRESHOLD_RESET = 8'd120;
  localparam cfg_data_t WIDTH_RESET = 8'd128;
  localparam cfg_data_t WIDTH_MIN = 8'd2;

  // result kinds
  localparam logic KIND_BAND = 1'b0;
  localparam logic KIND_SEG = 1'b1;

  typedef enum logic {
    WALK_IDLE,
    WALK_SCAN
  } walk_state_e;

  // request from the pixel front end to the column walk
  typedef struct packed {
    logic     start;
    logic     report;
    row_out_t top;
    row_out_t bottom;
  } walk_req_t;

endpackage

FILE: sv/pps_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module pps_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: sv/pps_walk.sv
// column walk: scans the column flag memory, reports the band and its glyph
// segments on a report request, and clears every entry behind it; depends on pps_pkg
module pps_walk #(
  parameter int MAX_WIDTH = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pps_pkg::walk_req_t            req_i,
  input  logic [$clog2(MAX_WIDTH):0]    width_i,
  output logic                          busy_o,
  output logic                          rd_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  rd_addr_o,
  input  logic                          rd_data_i,
  output logic                          wr_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  wr_addr_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          kind_o,
  output pps_pkg::row_out_t             band_top_o,
  output pps_pkg::row_out_t             band_bottom_o,
  output pps_pkg::col_out_t             seg_left_o,
  output pps_pkg::col_out_t             seg_right_o,
  output logic                          last_of_run_o
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [AW:0] ADDR_END = (AW+1)'(MAX_WIDTH);

  pps_pkg::walk_state_e state_q, state_d;

  logic [AW:0]       addr_q;
  logic              rv_q;
  logic              report_q;
  logic              pv_q;
  logic              run_q;
  logic              ov_q;
  logic [AW-1:0]     pc_q;
  logic [AW-1:0]     start_q;
  logic              pk_q;
  pps_pkg::col_out_t pl_q, pr_q;
  pps_pkg::row_out_t top_q, bot_q;

  logic scanning, begin_walk, in_band, seg_hit, out_free, stall, consume;
  logic at_end, flush, done, issue, load_mid, load_out;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pps_pkg::WALK_IDLE: begin
        if (req_i.start) state_d = pps_pkg::WALK_SCAN;
      end
      pps_pkg::WALK_SCAN: begin
        if (done) state_d = pps_pkg::WALK_IDLE;
      end
      default: state_d = pps_pkg::WALK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    scanning   = 1'b0;
    begin_walk = 1'b0;
    case (state_q)
      pps_pkg::WALK_IDLE: begin_walk = req_i.start;
      pps_pkg::WALK_SCAN: scanning = 1'b1;
      default: scanning = 1'b0;
    endcase
  end

  always_comb begin
    in_band  = {1'b0, pc_q} < width_i;
    // a white column closes a run of at least two dark columns
    seg_hit  = rv_q && report_q && in_band && !rd_data_i && run_q
               && (pc_q != start_q + AW'(1));
    out_free = !ov_q || out_ready_i;
    stall    = seg_hit && !out_free;
    consume  = rv_q && !stall;
    at_end   = (addr_q == ADDR_END) && !rv_q;
    flush    = scanning && at_end && pv_q && out_free;
    done     = scanning && at_end && (!pv_q || out_free);
    issue    = scanning && (addr_q != ADDR_END) && (!rv_q || consume);
    load_mid = consume && seg_hit;
    load_out = load_mid || flush;
  end

  assign busy_o    = scanning;
  assign rd_en_o   = issue;
  assign rd_addr_o = addr_q[AW-1:0];
  assign wr_en_o   = consume;
  assign wr_addr_o = pc_q;

  // reset starts a clearing pass over the whole memory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pps_pkg::WALK_SCAN;
      addr_q   <= '0;
      rv_q     <= 1'b0;
      report_q <= 1'b0;
      pv_q     <= 1'b0;
      run_q    <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (begin_walk) begin
        addr_q   <= '0;
        rv_q     <= 1'b0;
        run_q    <= 1'b0;
        report_q <= req_i.report;
        pv_q     <= req_i.report;
      end else begin
        if (issue) addr_q <= addr_q + (AW+1)'(1);
        rv_q <= issue || (rv_q && !consume);
        if (consume && report_q && in_band) run_q <= rd_data_i;
        if (flush) pv_q <= 1'b0;
      end
      if (load_out) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) pc_q <= addr_q[AW-1:0];
    if (consume && report_q && in_band && rd_data_i && !run_q) start_q <= pc_q;
    if (begin_walk) begin
      pk_q  <= pps_pkg::KIND_BAND;
      pl_q  <= '0;
      pr_q  <= '0;
      top_q <= req_i.top;
      bot_q <= req_i.bottom;
    end else if (load_mid) begin
      pk_q <= pps_pkg::KIND_SEG;
      pl_q <= pps_pkg::col_out_t'(start_q);
      pr_q <= pps_pkg::col_out_t'(pc_q - AW'(1));
    end
    if (load_out) begin
      kind_o        <= pk_q;
      seg_left_o    <= pl_q;
      seg_right_o   <= pr_q;
      band_top_o    <= top_q;
      band_bottom_o <= bot_q;
      last_of_run_o <= flush;
    end
  end

  assign out_valid_o = ov_q;

endmodule

FILE: sv/projection_profile_segmenter_unit.sv
// projection profile segmenter: row and band tracking, column flag memory and
// column walk; depends on pps_pkg, pps_ram, pps_walk
// throughput: one pixel per cycle; a white row end after dark flags stalls input
//   while the column walk runs, and so does a frame start over dark flags; the stall
//   lasts longer while the output register is held
// results appear during that walk; reset starts a clearing pass
module projection_profile_segmenter_unit #(
  parameter int MAX_WIDTH = 128,
  parameter int ROW_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            pixel_i,
  input  logic                  frame_start_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  kind_o,
  output pps_pkg::row_out_t     band_top_o,
  output pps_pkg::row_out_t     band_bottom_o,
  output pps_pkg::col_out_t     seg_left_o,
  output pps_pkg::col_out_t     seg_right_o,
  output logic                  last_of_run_o,
  input  logic                  cfg_we_i,
  input  pps_pkg::cfg_idx_t     cfg_idx_i,
  input  pps_pkg::cfg_data_t    cfg_data_i
);

  localparam int AW = $clog2(MAX_WIDTH);

  pps_pkg::cfg_data_t thr_q, width_q;
  logic [AW-1:0]       col_q;
  logic                rhd_q, ba_q, dirty_q;
  logic [ROW_BITS-1:0] bfr_q, ri_q;

  logic [AW-1:0]       col_c;
  logic                rhd_c, ba_c, rhd_n, dark, row_end, accept, busy;
  logic                band_report, clear_fs, px_we;
  logic [ROW_BITS-1:0] bfr_c, ri_c, bottom;
  logic [AW:0]         w_eff;
  pps_pkg::walk_req_t  req;

  logic          rd_en, rd_data, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [0:0]    ram_rdata;

  always_comb begin
    if (width_q < pps_pkg::WIDTH_MIN) begin
      w_eff = (AW+1)'(pps_pkg::WIDTH_MIN);
    end else if ({1'b0, width_q} > 9'(MAX_WIDTH)) begin
      w_eff = (AW+1)'(MAX_WIDTH);
    end else begin
      w_eff = width_q[AW:0];
    end
  end

  always_comb begin
    // frame start clears the row and band state before the pixel counts
    col_c = frame_start_i ? '0 : col_q;
    rhd_c = frame_start_i ? 1'b0 : rhd_q;
    ba_c  = frame_start_i ? 1'b0 : ba_q;
    bfr_c = frame_start_i ? '0 : bfr_q;
    ri_c  = frame_start_i ? '0 : ri_q;

    dark        = pixel_i < thr_q;
    rhd_n       = rhd_c || dark;
    row_end     = ((AW+1)'(col_c) + (AW+1)'(1)) >= w_eff;
    bottom      = ri_c - ROW_BITS'(1);
    band_report = row_end && !rhd_n && ba_c && (bottom != bfr_c);

    in_ready_o = !busy && !(frame_start_i && dirty_q);
    accept     = in_valid_i && in_ready_o;
    clear_fs   = in_valid_i && frame_start_i && dirty_q && !busy;
    px_we      = accept && dark;

    req.start  = clear_fs || (accept && row_end && !rhd_n && (band_report || dirty_q));
    req.report = accept && band_report;
    req.top    = pps_pkg::row_out_t'(bfr_c);
    req.bottom = pps_pkg::row_out_t'(bottom);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= pps_pkg::THRESHOLD_RESET;
      width_q <= pps_pkg::WIDTH_RESET;
      col_q   <= '0;
      rhd_q   <= 1'b0;
      ba_q    <= 1'b0;
      bfr_q   <= '0;
      ri_q    <= '0;
      dirty_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pps_pkg::REG_DARK_THRESHOLD: thr_q <= cfg_data_i;
          pps_pkg::REG_IMAGE_WIDTH:    width_q <= cfg_data_i;
          default: thr_q <= thr_q;
        endcase
      end
      if (req.start) begin
        dirty_q <= 1'b0;
      end else if (px_we) begin
        dirty_q <= 1'b1;
      end
      if (accept) begin
        if (row_end) begin
          if (rhd_n) begin
            ba_q  <= 1'b1;
            bfr_q <= ba_c ? bfr_c : ri_c;
          end else begin
            ba_q  <= 1'b0;
            bfr_q <= bfr_c;
          end
          rhd_q <= 1'b0;
          col_q <= '0;
          ri_q  <= ri_c + ROW_BITS'(1);
        end else begin
          ba_q  <= ba_c;
          bfr_q <= bfr_c;
          rhd_q <= rhd_n;
          col_q <= col_c + AW'(1);
          ri_q  <= ri_c;
        end
      end
    end
  end

  // dark pixels set their column flag; the walk writes zeros behind itself
  pps_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (px_we || wr_en),
    .waddr_i (wr_en ? wr_addr : col_c),
    .wdata_i (px_we),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign rd_data = ram_rdata[0];

  pps_walk #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .width_i       (w_eff),
    .busy_o        (busy),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .band_top_o    (band_top_o),
    .band_bottom_o (band_bottom_o),
    .seg_left_o    (seg_left_o),
    .seg_right_o   (seg_right_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

FILE: dv/tb_top.sv
// self-checking testbench of projection_profile_segmenter_unit: a clocked driver and
// monitor, a pixel-level line and glyph predictor, and directed then random frames
// depends on pps_pkg and the segmenter rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIDTH = 128;
  localparam int ROW_BITS = 12;

  typedef struct packed {
    logic              kind;
    pps_pkg::row_out_t top;
    pps_pkg::row_out_t bottom;
    pps_pkg::col_out_t left;
    pps_pkg::col_out_t right;
    logic              last;
  } span_t;

  typedef struct packed {
    logic [7:0] value;
    logic       start;
  } pixel_item_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [7:0]         pixel_i = 8'd0;
  logic               frame_start_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               kind_o;
  pps_pkg::row_out_t  band_top_o;
  pps_pkg::row_out_t  band_bottom_o;
  pps_pkg::col_out_t  seg_left_o;
  pps_pkg::col_out_t  seg_right_o;
  logic               last_of_run_o;
  logic               cfg_we_i = 1'b0;
  pps_pkg::cfg_idx_t  cfg_idx_i = pps_pkg::REG_DARK_THRESHOLD;
  pps_pkg::cfg_data_t cfg_data_i = 8'd0;

  projection_profile_segmenter_unit #(
    .MAX_WIDTH(MAX_WIDTH),
    .ROW_BITS (ROW_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_i      (pixel_i),
    .frame_start_i(frame_start_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .band_top_o   (band_top_o),
    .band_bottom_o(band_bottom_o),
    .seg_left_o   (seg_left_o),
    .seg_right_o  (seg_right_o),
    .last_of_run_o(last_of_run_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // line and glyph tracker state
  bit                 col_ink [MAX_WIDTH];
  bit                 row_ink;
  bit                 band_open;
  pps_pkg::row_out_t  band_top_q;
  pps_pkg::row_out_t  row_q;
  int unsigned        col_q;
  pps_pkg::cfg_data_t thr_q = pps_pkg::THRESHOLD_RESET;
  pps_pkg::cfg_data_t width_q = pps_pkg::WIDTH_RESET;

  pixel_item_t pixel_queue[$];
  span_t       expected_spans[$];
  pixel_item_t drv_item;
  span_t       seen_span;
  span_t       want_span;
  int          send_idle = 20;
  int          recv_idle = 61;
  int          errors = 0;

  function automatic int unsigned active_width();
    if (width_q < pps_pkg::WIDTH_MIN) return 2;
    if (int'(width_q) > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_q);
  endfunction

  task automatic scan_pixel(input logic [7:0] pix, input logic fs);
    span_t             found[$];
    span_t             r;
    int unsigned       w;
    int unsigned       col;
    int unsigned       start;
    bit                in_run;
    pps_pkg::row_out_t bottom;
    if (fs) begin
      foreach (col_ink[i]) col_ink[i] = 1'b0;
      row_ink = 1'b0;
      band_open = 1'b0;
      band_top_q = '0;
      row_q = '0;
      col_q = 0;
    end
    w = active_width();
    col = col_q;
    if (pix < thr_q) begin
      row_ink = 1'b1;
      col_ink[col] = 1'b1;
    end
    if (col + 1 >= w) begin
      if (row_ink) begin
        if (!band_open) begin
          band_open = 1'b1;
          band_top_q = row_q;
        end
      end else begin
        if (band_open) begin
          bottom = row_q - 1'b1;
          // a one-row band is not reported, also after a full wrap of the row counter
          if (bottom != band_top_q) begin
            r.kind = pps_pkg::KIND_BAND;
            r.top = band_top_q;
            r.bottom = bottom;
            r.left = '0;
            r.right = '0;
            r.last = 1'b0;
            found.push_back(r);
            in_run = 1'b0;
            start = 0;
            for (int c = 0; c < w; c++) begin
              if (col_ink[c]) begin
                if (!in_run) begin
                  in_run = 1'b1;
                  start = c;
                end
              end else begin
                if (in_run && c - 1 != start) begin
                  r.kind = pps_pkg::KIND_SEG;
                  r.left = pps_pkg::col_out_t'(start);
                  r.right = pps_pkg::col_out_t'(c - 1);
                  found.push_back(r);
                end
                in_run = 1'b0;
              end
            end
          end
          band_open = 1'b0;
        end
        foreach (col_ink[i]) col_ink[i] = 1'b0;
      end
      row_ink = 1'b0;
      col_q = 0;
      row_q = row_q + 1'b1;
    end else begin
      col_q = col + 1;
    end
    if (found.size() != 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) expected_spans.push_back(found[i]);
  endtask

  // driver: one transaction in flight, payload held until accepted
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) scan_pixel(pixel_i, frame_start_i);
      if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
        drv_item = pixel_queue.pop_front();
        in_valid_i <= 1'b1;
        pixel_i <= drv_item.value;
        frame_start_i <= drv_item.start;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        seen_span.kind = kind_o;
        seen_span.top = band_top_o;
        seen_span.bottom = band_bottom_o;
        seen_span.left = seg_left_o;
        seen_span.right = seg_right_o;
        seen_span.last = last_of_run_o;
        if (expected_spans.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %p", $time, seen_span);
          errors++;
        end else begin
          want_span = expected_spans.pop_front();
          check_field("kind", want_span.kind, seen_span.kind);
          check_field("band_top", want_span.top, seen_span.top);
          check_field("band_bottom", want_span.bottom, seen_span.bottom);
          check_field("seg_left", want_span.left, seen_span.left);
          check_field("seg_right", want_span.right, seen_span.right);
          check_field("last_of_run", want_span.last, seen_span.last);
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  // stimulus helpers
  function automatic logic [7:0] ink_pixel();
    int unsigned pick;
    if (thr_q == 0) return 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 3);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'(int'(thr_q) - 1);
    return 8'($urandom_range(0, int'(thr_q) - 1));
  endfunction

  function automatic logic [7:0] paper_pixel();
    int unsigned pick;
    pick = $urandom_range(0, 3);
    if (pick == 0) return 8'd255;
    if (pick == 1) return thr_q;
    return 8'($urandom_range(int'(thr_q), 255));
  endfunction

  task automatic put_pixel(logic [7:0] v, logic fs);
    pixel_item_t it;
    it.value = v;
    it.start = fs;
    pixel_queue.push_back(it);
  endtask

  function automatic logic [MAX_WIDTH-1:0] make_template(int unsigned w);
    logic [MAX_WIDTH-1:0] t;
    int unsigned c;
    int unsigned len;
    bit          on;
    t = '0;
    c = 0;
    on = ($urandom_range(0, 1) != 0);
    while (c < w) begin
      len = $urandom_range(1, 4);
      for (int k = 0; k < len && c < w; k++) begin
        t[c] = on;
        c++;
      end
      on = !on;
    end
    return t;
  endfunction

  task automatic emit_row(logic [MAX_WIDTH-1:0] tmpl, bit dark, bit fs, int dens);
    int unsigned w;
    int unsigned force_col;
    w = active_width();
    force_col = $urandom_range(0, w - 1);
    if ((tmpl & ((MAX_WIDTH'(1) << w) - 1'b1)) != 0 || w == MAX_WIDTH && tmpl != 0)
      while (!tmpl[force_col]) force_col = $urandom_range(0, w - 1);
    else
      tmpl[force_col] = 1'b1;
    for (int c = 0; c < w; c++) begin
      if (dark && tmpl[c] && (c == force_col || $urandom_range(99) < dens))
        put_pixel(ink_pixel(), fs && c == 0);
      else
        put_pixel(paper_pixel(), fs && c == 0);
    end
  endtask

  // alternating white gaps and text bands, one and several rows high
  task automatic emit_frame(int rows, bit fs);
    logic [MAX_WIDTH-1:0] tmpl;
    int n;
    int r;
    bit first;
    r = 0;
    first = fs;
    while (r < rows) begin
      n = $urandom_range(1, 2);
      for (int k = 0; k < n; k++) begin
        emit_row('0, 1'b0, first, 0);
        first = 1'b0;
      end
      r += n;
      tmpl = make_template(active_width());
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++) begin
        emit_row(tmpl, 1'b1, first, 60);
        first = 1'b0;
      end
      r += n;
    end
    emit_row('0, 1'b0, first, 0);
  endtask

  task automatic emit_noise(int n);
    for (int k = 0; k < n; k++)
      put_pixel(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
  endtask

  // hold the sender until the block has drained and finished its column pass
  task automatic settle();
    while (pixel_queue.size() != 0 || in_valid_i || expected_spans.size() != 0)
      @(posedge clk_i);
    repeat (MAX_WIDTH + 20) @(posedge clk_i);
  endtask

  task automatic write_reg(pps_pkg::cfg_idx_t idx, pps_pkg::cfg_data_t val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == pps_pkg::REG_DARK_THRESHOLD) thr_q = val;
    else if (idx == pps_pkg::REG_IMAGE_WIDTH) width_q = val;
  endtask

  initial begin
    logic [MAX_WIDTH-1:0] tmpl;
    int pick;
    pps_pkg::cfg_data_t wsel;
    pps_pkg::cfg_data_t tsel;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // reset settings, widest band with 2-column glyphs every third column and a
    // run into the last column; the second row comes with a width above range
    tmpl = '0;
    for (int c = 0; c < MAX_WIDTH; c++) tmpl[c] = (c % 3 != 2);
    emit_row(tmpl, 1'b1, 1'b1, 100);
    settle();
    write_reg(pps_pkg::REG_IMAGE_WIDTH, 8'd200);
    emit_row(tmpl, 1'b1, 1'b0, 100);
    emit_row('0, 1'b0, 1'b0, 0);
    settle();

    // zero threshold and width below range: nothing is ink
    write_reg(pps_pkg::REG_DARK_THRESHOLD, 8'd0);
    write_reg(pps_pkg::REG_IMAGE_WIDTH, 8'd0);
    emit_row('1, 1'b1, 1'b1, 100);
    emit_row('1, 1'b1, 1'b0, 100);
    emit_row('0, 1'b0, 1'b0, 0);
    settle();

    // full threshold, width one: single dark row, single column, run to the edge
    write_reg(pps_pkg::REG_DARK_THRESHOLD, 8'd255);
    write_reg(pps_pkg::REG_IMAGE_WIDTH, 8'd1);
    emit_row(MAX_WIDTH'(1), 1'b1, 1'b1, 100);
    emit_row('0, 1'b0, 1'b0, 0);
    emit_row(MAX_WIDTH'(1), 1'b1, 1'b0, 100);
    emit_row(MAX_WIDTH'(1), 1'b1, 1'b0, 100);
    emit_row('0, 1'b0, 1'b0, 0);
    emit_row(MAX_WIDTH'(3), 1'b1, 1'b0, 100);
    emit_row(MAX_WIDTH'(3), 1'b1, 1'b0, 100);
    emit_row('0, 1'b0, 1'b0, 0);
    settle();

    // width shrinks in the middle of a row
    write_reg(pps_pkg::REG_DARK_THRESHOLD, pps_pkg::THRESHOLD_RESET);
    write_reg(pps_pkg::REG_IMAGE_WIDTH, 8'd8);
    put_pixel(ink_pixel(), 1'b1);
    put_pixel(ink_pixel(), 1'b0);
    put_pixel(paper_pixel(), 1'b0);
    settle();
    write_reg(pps_pkg::REG_IMAGE_WIDTH, 8'd2);
    put_pixel(paper_pixel(), 1'b0);
    emit_row(MAX_WIDTH'(1), 1'b1, 1'b0, 100);
    emit_row('0, 1'b0, 1'b0, 0);
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      if (phase < 2) begin
        send_idle = 20;
        recv_idle = 61;
      end else if (phase < 4) begin
        send_idle = 61;
        recv_idle = 20;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) tsel = 8'd0;
      else if (pick == 1) tsel = 8'd255;
      else tsel = 8'($urandom_range(40, 220));
      pick = $urandom_range(0, 9);
      if (pick == 0) wsel = 8'd0;
      else if (pick == 1) wsel = 8'd1;
      else wsel = 8'($urandom_range(2, 5));
      write_reg(pps_pkg::REG_DARK_THRESHOLD, tsel);
      write_reg(pps_pkg::REG_IMAGE_WIDTH, wsel);
      emit_frame(1, $urandom_range(0, 9) != 0);
      if ($urandom_range(0, 3) == 0) emit_noise($urandom_range(5, 15));
      settle();
    end

    settle();
    repeat (MAX_WIDTH * 2) @(posedge clk_i);
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: files.f
sv/pps_pkg.sv
sv/pps_ram.sv
sv/pps_walk.sv
sv/projection_profile_segmenter_unit.sv
dv/tb_top.sv
